FILE: rtl/scy_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scy_pkg;

    // Width of the grid geometry values (diameter, letter count, rows)
    localparam int GEOM_W = 7;
    // Width of the address and column walk registers (holds a sum of two geometry values)
    localparam int WALK_W = GEOM_W + 1;

    // Configuration register indexes
    localparam logic REG_DIAMETER = 1'b0;
    localparam logic REG_DECRYPT  = 1'b1;

    // ASCII letter bounds
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;
    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] UPPER_Z = 8'd90;

    // Grid geometry handed to the address walker
    typedef struct packed {
        logic [GEOM_W-1:0] diam;     // effective column count, never zero
        logic [GEOM_W-1:0] letters;  // letters in the text
        logic [GEOM_W-1:0] rows;     // ceil(letters / diam)
        logic [GEOM_W-1:0] full_cols; // columns that reach the last row
    } geom_t;

    // Control of the address walker
    typedef struct packed {
        logic init;
        logic step;
        logic decrypt;
    } walk_ctrl_t;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= LOWER_A) && (c <= LOWER_Z)) || ((c >= UPPER_A) && (c <= UPPER_Z));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/scy_store.sv
`timescale 1ns / 1ps
`default_nettype none

module scy_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic              clk,
    input  wire logic              text_we,
    input  wire logic [ADDR_W-1:0] text_waddr,
    input  wire logic              letter_we,
    input  wire logic [ADDR_W-1:0] letter_waddr,
    input  wire logic [7:0]        wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] text_raddr,
    input  wire logic [ADDR_W-1:0] letter_raddr,
    output logic      [7:0]        text_q,
    output logic      [7:0]        letter_q
);

    logic [7:0] text_mem   [DEPTH];
    logic [7:0] letter_mem [DEPTH];
    logic [7:0] text_q_reg;
    logic [7:0] letter_q_reg;

    // Write the byte in text order and, if a letter, in letter order
    always_ff @(posedge clk)
    begin
        if (text_we)
        begin
            text_mem[text_waddr] <= wdata;
        end
        if (letter_we)
        begin
            letter_mem[letter_waddr] <= wdata;
        end
    end

    // Read both stores, hold the data until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            text_q_reg   <= text_mem[text_raddr];
            letter_q_reg <= letter_mem[letter_raddr];
        end
    end

    assign text_q   = text_q_reg;
    assign letter_q = letter_q_reg;

endmodule

`default_nettype wire

FILE: rtl/scy_rows.sv
`timescale 1ns / 1ps
`default_nettype none

module scy_rows (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [scy_pkg::GEOM_W-1:0] letters,
    input  wire logic [scy_pkg::GEOM_W-1:0] diam,
    output logic                            busy,
    output logic      [scy_pkg::GEOM_W-1:0] rows,
    output logic      [scy_pkg::GEOM_W-1:0] full_cols
);

    import scy_pkg::*;

    logic              busy_reg;
    logic              busy_next;
    logic [GEOM_W-1:0] rem_reg;
    logic [GEOM_W-1:0] rem_next;
    logic [GEOM_W-1:0] rows_reg;
    logic [GEOM_W-1:0] rows_next;

    // Take off one row per cycle until the last, partial or full, row is left
    always_comb
    begin
        busy_next = busy_reg;
        rem_next  = rem_reg;
        rows_next = rows_reg;
        if (start)
        begin
            busy_next = 1'b1;
            rem_next  = letters;
            rows_next = '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg > diam)
            begin
                rem_next  = rem_reg - diam;
                rows_next = rows_reg + 1'b1;
            end
            else
            begin
                busy_next = 1'b0;
                if (rem_reg != '0)
                begin
                    rows_next = rows_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        rows_reg <= rows_next;
    end

    assign busy      = busy_reg;
    assign rows      = rows_reg;
    assign full_cols = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/scy_walk.sv
`timescale 1ns / 1ps
`default_nettype none

module scy_walk (
    input  wire logic                       clk,
    input  wire scy_pkg::walk_ctrl_t        ctrl,
    input  wire scy_pkg::geom_t             geom,
    output logic      [scy_pkg::WALK_W-1:0] addr
);

    import scy_pkg::*;

    logic [WALK_W-1:0] addr_reg;
    logic [WALK_W-1:0] addr_next;
    logic [WALK_W-1:0] col_reg;
    logic [WALK_W-1:0] col_next;
    logic [WALK_W-1:0] row_reg;
    logic [WALK_W-1:0] row_next;
    logic [WALK_W-1:0] sum;
    logic [WALK_W-1:0] col_inc;
    logic              col_tall;

    assign col_inc  = col_reg + 1'b1;
    assign col_tall = col_reg < {1'b0, geom.full_cols};

    // Shared adder: next cell down a column, or the height of the current column
    always_comb
    begin
        if (ctrl.decrypt)
        begin
            sum = addr_reg + {1'b0, geom.rows} - 1'b1 + {{(WALK_W-1){1'b0}}, col_tall};
        end
        else
        begin
            sum = addr_reg + {1'b0, geom.diam};
        end
    end

    // Advance the letter address one letter position
    always_comb
    begin
        addr_next = addr_reg;
        col_next  = col_reg;
        row_next  = row_reg;
        if (ctrl.init)
        begin
            addr_next = '0;
            col_next  = '0;
            row_next  = '0;
        end
        else if (ctrl.step)
        begin
            if (ctrl.decrypt)
            begin
                // Row-major walk: letter index is the column-major cell count
                if (col_inc == {1'b0, geom.diam})
                begin
                    col_next  = '0;
                    row_next  = row_reg + 1'b1;
                    addr_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next  = col_inc;
                    addr_next = sum;
                end
            end
            else
            begin
                // Column-major walk over the row-major cells, skip empty ones
                if (sum >= {1'b0, geom.letters})
                begin
                    col_next  = col_inc;
                    addr_next = col_inc;
                end
                else
                begin
                    addr_next = sum;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        col_reg  <= col_next;
        row_reg  <= row_next;
    end

    assign addr = addr_reg;

endmodule

`default_nettype wire

FILE: rtl/scytale_transposition_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Flow: bytes load one per cycle while loading; after the last byte, the start state
// and the row count by scy_rows pass before the first output item.
// Each output item waits for a registered read of the text and letter stores, and no
// input is taken until the whole text has been output.
// Reset (rst_n, asynchronous, active low): counts and flags clear, diameter 1, encrypt;
// the stores hold no defined data until written.
module scytale_transposition_top #(
    parameter int MAX_LEN = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] in_char
    input  wire logic        s_tlast,
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,   // [7:0] out_char
    output logic             m_tlast,
    output logic             m_tuser,   // [0] overflow
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    import scy_pkg::*;

    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);

    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [CNT_W-1:0]  text_cnt_reg;
    logic [CNT_W-1:0]  text_cnt_next;
    logic [CNT_W-1:0]  letter_cnt_reg;
    logic [CNT_W-1:0]  letter_cnt_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [GEOM_W-1:0] diameter_reg;
    logic              decrypt_reg;

    logic              in_acc;
    logic              out_acc;
    logic              has_room;
    logic              in_letter;
    logic              cfg_wr;
    logic [7:0]        text_q;
    logic [7:0]        letter_q;
    logic              text_is_letter;
    logic              final_item;
    logic              rows_busy;
    logic [WALK_W-1:0] walk_addr;
    geom_t             geom;
    walk_ctrl_t        walk_ctrl;

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diameter_reg <= GEOM_W'(1);
            decrypt_reg  <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_DIAMETER: diameter_reg <= pwdata[GEOM_W-1:0];
                REG_DECRYPT:  decrypt_reg  <= pwdata[0];
                default:      diameter_reg <= diameter_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_DIAMETER: prdata = {{(32-GEOM_W){1'b0}}, diameter_reg};
            REG_DECRYPT:  prdata = {31'd0, decrypt_reg};
            default:      prdata = '0;
        endcase
    end

    // Handshakes and item flags
    assign s_tready       = (state_reg == S_LOAD);
    assign m_tvalid       = (state_reg == S_OUT);
    assign in_acc         = s_tvalid && s_tready;
    assign out_acc        = m_tvalid && m_tready;
    assign has_room       = text_cnt_reg < CNT_W'(MAX_LEN);
    assign in_letter      = is_letter(s_tdata);
    assign text_is_letter = is_letter(text_q);
    assign final_item     = (CNT_W'(idx_reg) + 1'b1) == text_cnt_reg;

    assign m_tdata = text_is_letter ? letter_q : text_q;
    assign m_tlast = final_item;
    assign m_tuser = ovf_reg;

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        text_cnt_next   = text_cnt_reg;
        letter_cnt_next = letter_cnt_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_acc)
                begin
                    if (has_room)
                    begin
                        text_cnt_next = text_cnt_reg + 1'b1;
                        if (in_letter)
                        begin
                            letter_cnt_next = letter_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                idx_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!rows_busy)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    if (final_item)
                    begin
                        text_cnt_next   = '0;
                        letter_cnt_next = '0;
                        ovf_next        = 1'b0;
                        state_next      = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_LOAD;
            text_cnt_reg   <= '0;
            letter_cnt_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            text_cnt_reg   <= text_cnt_next;
            letter_cnt_reg <= letter_cnt_next;
            ovf_reg        <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
    end

    // Text and letter stores
    scy_store #(
        .DEPTH  (MAX_LEN),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk          (clk),
        .text_we      (in_acc && has_room),
        .text_waddr   (text_cnt_reg[ADDR_W-1:0]),
        .letter_we    (in_acc && has_room && in_letter),
        .letter_waddr (letter_cnt_reg[ADDR_W-1:0]),
        .wdata        (s_tdata),
        .re           (state_reg == S_READ),
        .text_raddr   (idx_reg),
        .letter_raddr (walk_addr[ADDR_W-1:0]),
        .text_q       (text_q),
        .letter_q     (letter_q)
    );

    // Grid geometry
    assign geom.diam    = (diameter_reg == '0) ? GEOM_W'(1) : diameter_reg;
    assign geom.letters = GEOM_W'(letter_cnt_reg);

    scy_rows u_rows (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (state_reg == S_START),
        .letters   (geom.letters),
        .diam      (geom.diam),
        .busy      (rows_busy),
        .rows      (geom.rows),
        .full_cols (geom.full_cols)
    );

    // Letter address walk, one step per letter emitted
    assign walk_ctrl.init    = (state_reg == S_START);
    assign walk_ctrl.step    = out_acc && text_is_letter;
    assign walk_ctrl.decrypt = decrypt_reg;

    scy_walk u_walk (
        .clk  (clk),
        .ctrl (walk_ctrl),
        .geom (geom),
        .addr (walk_addr)
    );

endmodule

`default_nettype wire

FILE: tb/scytale_transposition_top_test.sv
`timescale 1ns / 1ps

module scytale_transposition_top_test;
    import scy_pkg::*;

    localparam int TEXT_MAX      = 64;
    localparam int RANDOM_ITEMS  = 190;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 100;
    localparam int N_DIRECTED    = 28;

    typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

    // One row of the directed table: a text byte, or a register write
    typedef struct {
        row_kind_t   kind;
        logic [7:0]  ch;
        logic        last;
        bit          typed;
        logic [7:0]  want;
        logic        reg_idx;
        logic [31:0] value;
    } stim_row_t;

    // One byte of the emitted text
    typedef struct {
        logic [7:0] ch;
        logic       last;
        logic       ovf;
    } cipher_byte_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] in_char
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_char
    logic        m_tlast;
    logic        m_tuser;   // [0] overflow
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Expected output text and the scrambler's own copy of the block state
    cipher_byte_t cipher_q[$];
    logic [7:0]   text_buf [TEXT_MAX];
    int           text_len = 0;
    bit           text_ovf = 1'b0;
    logic [6:0]   cfg_diameter = 7'd1;
    logic         cfg_decrypt = 1'b0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int fail_count     = 0;
    int cycle_count    = 0;

    scytale_transposition_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    // Permute the letters of the held text on the grid and queue the whole text
    function automatic void scramble_text();
        logic [7:0] letters [TEXT_MAX];
        logic [7:0] perm [TEXT_MAX];
        int         cell_order [TEXT_MAX];
        int         n;
        int         d;
        int         rows;
        int         k;
        int         li;
        int         p;
        logic [7:0] b;
        n = 0;
        for (int i = 0; i < text_len; i++)
            if (is_alpha(text_buf[i]))
            begin
                letters[n] = text_buf[i];
                n++;
            end
        d = (cfg_diameter == 7'd0) ? 1 : int'(cfg_diameter);
        rows = (n + d - 1) / d;
        // walk the grid column by column, skipping the empty cells of the last row
        k = 0;
        for (int j = 0; j < d; j++)
            for (int i = 0; i < rows; i++)
            begin
                p = i * d + j;
                if (p < n && k < TEXT_MAX)
                begin
                    cell_order[k] = p;
                    k++;
                end
            end
        for (int i = 0; i < n; i++)
            if (cfg_decrypt)
                perm[cell_order[i]] = letters[i];
            else
                perm[i] = letters[cell_order[i]];
        li = 0;
        for (int i = 0; i < text_len; i++)
        begin
            b = text_buf[i];
            if (is_alpha(b) && li < n)
            begin
                b = perm[li];
                li++;
            end
            cipher_q.push_back('{b, (i == text_len - 1), text_ovf});
        end
        text_len = 0;
        text_ovf = 1'b0;
    endfunction

    // Store or drop one accepted byte; the last byte releases the text
    function automatic void take_byte(logic [7:0] c, logic last);
        if (text_len < TEXT_MAX)
        begin
            text_buf[text_len] = c;
            text_len++;
        end
        else
            text_ovf = 1'b1;
        if (last)
            scramble_text();
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        $display("%0t: %s mismatch: got %02h, want %02h", $time, what, got, want);
        fail_count++;
    endtask

    // Offer one byte after a random gap; called and returning at a falling edge
    task automatic send_item(logic [7:0] c, logic last);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        take_byte(c, last);
        @(negedge clk);
    endtask

    // Hold the input until every expected byte has come out and the block settles
    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (cipher_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_DIAMETER)
            cfg_diameter = value[6:0];
        else
            cfg_decrypt = value[0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    function automatic logic [7:0] random_text_byte();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 8'($urandom_range(65, 90));
        else if (r < 80)
            return 8'($urandom_range(97, 122));
        else
            return 8'($urandom_range(255));
    endfunction

    // Mostly short texts; one exactly full, one overflowing, a few long ones
    function automatic int text_length(int text_no);
        int r;
        if (text_no == 2)
            return TEXT_MAX;
        if (text_no == 5)
            return TEXT_MAX + 1;
        r = $urandom_range(99);
        if (r < 3)
            return $urandom_range(60, 70);
        else if (r < 10)
            return $urandom_range(13, 40);
        else
            return $urandom_range(1, 10);
    endfunction

    function automatic logic [31:0] random_diameter();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom_range(1, 6);
        else if (r < 70)
            return $urandom_range(7, 20);
        else if (r < 80)
            return 0;
        else if (r < 90)
            return $urandom_range(64, 127);
        else
            return $urandom_range(127);
    endfunction

    // Randomly stall the output side
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Compare each output byte with the oldest expectation
    always @(posedge clk)
    begin : check_output
        cipher_byte_t exp_byte;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (cipher_q.size() == 0)
                report_mismatch("unexpected out_char", m_tdata, 8'h00);
            else
            begin
                exp_byte = cipher_q.pop_front();
                if (m_tdata !== exp_byte.ch)
                    report_mismatch("out_char", m_tdata, exp_byte.ch);
                if (m_tlast !== exp_byte.last)
                    report_mismatch("out_last", 8'(m_tlast), 8'(exp_byte.last));
                if (m_tuser !== exp_byte.ovf)
                    report_mismatch("overflow", 8'(m_tuser), 8'(exp_byte.ovf));
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("scytale_transposition_top_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        stim_row_t  directed_rows [N_DIRECTED];
        bit         typed_ok [TEXT_MAX];
        logic [7:0] typed_ch [TEXT_MAX];
        int         pos;
        int         base;
        int         items_sent;
        int         phase;
        int         text_no;
        int         len;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tlast  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = 3'd0;
        pwdata   = 32'd0;
        for (int i = 0; i < TEXT_MAX; i++)
            typed_ok[i] = 1'b0;

        // Reset values show every byte unchanged; then a broken last row both ways
        directed_rows = '{
            '{ROW_ITEM,  8'h41, 1'b1, 1'b1, 8'h41, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h00, 1'b0, 1'b1, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'hFF, 1'b0, 1'b1, 8'hFF, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h40, 1'b0, 1'b1, 8'h40, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h41, 1'b0, 1'b1, 8'h41, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h5B, 1'b0, 1'b1, 8'h5B, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h5A, 1'b0, 1'b1, 8'h5A, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h60, 1'b0, 1'b1, 8'h60, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h61, 1'b0, 1'b1, 8'h61, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h7B, 1'b0, 1'b1, 8'h7B, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h7A, 1'b1, 1'b1, 8'h7A, REG_DIAMETER, 32'd0},
            '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd3},
            '{ROW_ITEM,  8'h41, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h42, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h43, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h2D, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h44, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h45, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h46, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h47, 1'b1, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_WRITE, 8'h00, 1'b0, 1'b0, 8'h00, REG_DECRYPT,  32'd1},
            '{ROW_ITEM,  8'h41, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h44, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h47, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h42, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h45, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h43, 1'b0, 1'b0, 8'h00, REG_DIAMETER, 32'd0},
            '{ROW_ITEM,  8'h46, 1'b1, 1'b0, 8'h00, REG_DIAMETER, 32'd0}
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table; typed values replace the scrambler's bytes
        pos = 0;
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
            begin
                hold_until_drained();
                write_reg(directed_rows[r].reg_idx, directed_rows[r].value);
            end
            else
            begin
                send_item(directed_rows[r].ch, directed_rows[r].last);
                typed_ok[pos] = directed_rows[r].typed;
                typed_ch[pos] = directed_rows[r].want;
                pos++;
                if (directed_rows[r].last)
                begin
                    base = cipher_q.size() - pos;
                    for (int i = 0; i < pos; i++)
                    begin
                        if (typed_ok[i])
                            cipher_q[base + i].ch = typed_ch[i];
                        typed_ok[i] = 1'b0;
                    end
                    pos = 0;
                end
            end
        end

        // Random texts in phases; each phase drains, reconfigures and changes idling
        items_sent = 0;
        phase = 0;
        text_no = 0;
        while (items_sent < RANDOM_ITEMS || phase < 4)
        begin
            hold_until_drained();
            send_idle_pct  = 0;
            recv_stall_pct = 0;
            case (phase)
                0: write_reg(REG_DIAMETER, 32'd0);
                1: write_reg(REG_DIAMETER, 32'd127);
                2: write_reg(REG_DIAMETER, 32'd64);
                3: write_reg(REG_DIAMETER, 32'd1);
                default: write_reg(REG_DIAMETER, random_diameter());
            endcase
            if (phase < 4)
                write_reg(REG_DECRYPT, 32'(phase % 2));
            else
                write_reg(REG_DECRYPT, 32'($urandom_range(1)));
            case (phase % 4)
                1: send_idle_pct = 66;
                2: recv_stall_pct = 66;
                3:
                begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
                default: ;
            endcase
            repeat ($urandom_range(1, 3))
            begin
                len = text_length(text_no);
                for (int i = 0; i < len; i++)
                    send_item(random_text_byte(), (i == len - 1));
                items_sent += len;
                text_no++;
            end
            phase++;
        end

        // Let the last text drain, then watch for stray output
        s_tvalid <= 1'b0;
        while (cipher_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("scytale_transposition_top_test OK");
        else
            $display("scytale_transposition_top_test NOT OK");
        $finish;
    end

endmodule
